[design/chs_geometry_translator_unit_defines.svh]
// ----------------------------------------------------------------------------
// chs geometry translator assertion macros
// shared assertion helpers for the translator top level
// ----------------------------------------------------------------------------
`ifndef CHS_GEOMETRY_TRANSLATOR_UNIT_DEFINES_SVH
`define CHS_GEOMETRY_TRANSLATOR_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define CHS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define CHS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/chs_pkg.sv]
// ----------------------------------------------------------------------------
// chs geometry translator package
// shared types and constants
// ----------------------------------------------------------------------------
package chs_pkg;

  localparam logic [31:0] CYL_LIMIT   = 32'd1024;
  localparam logic [31:0] HEAD_LIMIT  = 32'd256;
  localparam logic [31:0] SECT_LIMIT  = 32'd64;
  localparam logic [6:0]  TYPES_RESET = 7'd47;

  localparam logic KIND_LOAD     = 1'b0;
  localparam logic KIND_DIAGNOSE = 1'b1;

  localparam logic [1:0] VERDICT_SMALLER = 2'd0;
  localparam logic [1:0] VERDICT_EQUAL   = 2'd1;
  localparam logic [1:0] VERDICT_LARGER  = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [5:0]  entry_index;
    logic [15:0] entry_cylinders;
    logic [7:0]  entry_heads;
    logic [7:0]  entry_sectors;
    logic [15:0] phys_cylinders;
    logic [7:0]  phys_heads;
    logic [7:0]  phys_sectors;
    logic [15:0] bios_cylinders;
    logic [7:0]  bios_heads;
    logic [7:0]  bios_sectors;
  } chs_in_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [30:0] unused_kb;
    logic        many_cylinders;
    logic        suggest;
    logic [31:0] new_cylinders;
    logic [31:0] new_heads;
    logic [31:0] new_sectors;
    logic [6:0]  best_type;
    logic [30:0] leftover_kb;
    logic        stuck_on_prime;
  } chs_out_t;

  // handshake between top level and divider
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } chs_div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic        rem_zero;
  } chs_div_rsp_t;

endpackage

[design/chs_if.sv]
// ----------------------------------------------------------------------------
// chs stream interface
// valid/ready channel carrying one payload type
// ----------------------------------------------------------------------------
interface chs_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/chs_div.sv]
// ----------------------------------------------------------------------------
// chs divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module chs_div
  import chs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  chs_div_req_t req,
  output chs_div_rsp_t rsp
);

  logic [31:0] quo_r, quo_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dvs_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[31]};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = 32'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (req.start) begin
      dvs_r <= req.divisor;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;
  assign rsp.rem_zero = (rem_r == 32'd0);

endmodule

[design/chs_geometry_translator_unit.sv]
// sequence: load beat written straight to the table; diagnose beat with no suggestion
// passes capture, compare and output; otherwise the bit-serial divider runs once per
// trial divisor tried, then fit setup and a read, multiply, compare step per entry
// throughput: one beat at a time; the divider and the table read port set it
// reset: control state clears, types_r returns to 47; table contents
// stay undefined until loaded
`include "chs_geometry_translator_unit_defines.svh"
// ----------------------------------------------------------------------------
// chs geometry translator unit
// drive-type table, capacity diagnosis, chs translation and best fit
// ----------------------------------------------------------------------------
module chs_geometry_translator_unit
  import chs_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  chs_if.sink                     in_ch,
  chs_if.source                   out_ch,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [6:0]              cfg_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [8:0] DEPTH9 = 9'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CAP, ST_CMP, ST_DIV_GO, ST_DIV_WAIT, ST_STEP,
    ST_FIT_INIT, ST_FIT_RD, ST_FIT_MUL, ST_FIT_CMP, ST_FIT_DONE, ST_OUT
  } state_t;

  // translation stage: cylinders, heads, sectors
  typedef enum logic [1:0] {PH_CYL, PH_HEAD, PH_SECT} phase_t;

  chs_in_t     in_d;
  state_t      state_r;
  phase_t      phase_r;
  logic [6:0]  types_r;
  logic [31:0] mem [TABLE_DEPTH];
  logic [31:0] rd_r;

  logic [31:0] cyl_r, heads_r, sect_r, d_r, quo_r;
  logic [47:0] phys_r, bios_r, cap_r, ec_r, space_r;
  logic [23:0] ch_r;
  logic [8:0]  idx_r, n_r;
  logic [6:0]  best_r;
  logic        stuck_r, many_r, sugg_r;
  logic [1:0]  verdict_r;
  logic [30:0] unused_r;
  logic        out_valid_r;
  chs_out_t    out_r;

  chs_div_req_t div_req;
  chs_div_rsp_t div_rsp;

  logic [31:0] cur;
  logic [31:0] lim;
  logic [AW-1:0] rd_addr;

  assign in_d = in_ch.data;

  chs_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  always_comb begin
    case (phase_r)
      PH_CYL:  begin cur = cyl_r;   lim = CYL_LIMIT;  end
      PH_HEAD: begin cur = heads_r; lim = HEAD_LIMIT; end
      default: begin cur = sect_r;  lim = SECT_LIMIT; end
    endcase
  end

  assign div_req.start    = (state_r == ST_DIV_GO);
  assign div_req.dividend = cur;
  assign div_req.divisor  = d_r;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign cfg_ready   = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;
  assign rd_addr = idx_r[AW-1:0];

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready && in_d.kind == KIND_LOAD &&
        9'(in_d.entry_index) < DEPTH9) begin
      mem[AW'(in_d.entry_index)] <=
        {in_d.entry_sectors, in_d.entry_heads, in_d.entry_cylinders};
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      types_r     <= TYPES_RESET;
      out_valid_r <= 1'b0;
      phase_r     <= PH_CYL;
    end else begin
      if (cfg_valid && cfg_ready) begin
        types_r <= cfg_data;
      end
      if (out_ch.valid && out_ch.ready && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid && in_d.kind == KIND_DIAGNOSE) begin
            cyl_r   <= 32'(in_d.phys_cylinders);
            heads_r <= 32'(in_d.phys_heads);
            sect_r  <= 32'(in_d.phys_sectors);
            ch_r    <= 24'(in_d.phys_cylinders * in_d.phys_heads);
            ec_r    <= 48'(in_d.bios_cylinders * in_d.bios_heads);
            quo_r   <= 32'(in_d.bios_sectors);
            d_r     <= 32'(in_d.phys_sectors);
            many_r  <= (32'(in_d.bios_cylinders) >= CYL_LIMIT);
            state_r <= ST_CAP;
          end
        end
        ST_CAP: begin
          phys_r  <= 48'(ch_r * d_r[7:0]);
          bios_r  <= 48'(ec_r[23:0] * quo_r[7:0]);
          state_r <= ST_CMP;
        end
        ST_CMP: begin
          verdict_r <= (bios_r < phys_r) ? VERDICT_SMALLER :
                       (bios_r == phys_r) ? VERDICT_EQUAL : VERDICT_LARGER;
          unused_r  <= (bios_r < phys_r) ? 31'((phys_r - bios_r) >> 1) : '0;
          sugg_r    <= (bios_r != phys_r) || many_r;
          stuck_r   <= 1'b0;
          phase_r   <= PH_CYL;
          d_r       <= 32'd2;
          if ((bios_r != phys_r) || many_r) begin
            state_r <= ST_DIV_GO;
          end else begin
            state_r <= ST_OUT;
          end
        end
        ST_DIV_GO: begin
          // loop test of the current stage
          if (cur < lim) begin
            d_r <= 32'd2;
            if (phase_r == PH_SECT) begin
              state_r <= ST_FIT_INIT;
            end else begin
              phase_r <= (phase_r == PH_CYL) ? PH_HEAD : PH_SECT;
            end
          end else if (d_r >= cur) begin
            if (phase_r != PH_CYL) begin
              stuck_r <= 1'b1;
            end
            d_r <= 32'd2;
            if (phase_r == PH_SECT) begin
              state_r <= ST_FIT_INIT;
            end else begin
              phase_r <= (phase_r == PH_CYL) ? PH_HEAD : PH_SECT;
            end
          end else begin
            state_r <= ST_DIV_WAIT;
          end
        end
        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            quo_r <= div_rsp.quotient;
            if (div_rsp.rem_zero) begin
              state_r <= ST_STEP;
            end else begin
              d_r     <= d_r + 32'd1;
              state_r <= ST_DIV_GO;
            end
          end
        end
        ST_STEP: begin
          case (phase_r)
            PH_CYL: begin
              cyl_r   <= quo_r;
              heads_r <= 32'(heads_r * d_r);
            end
            PH_HEAD: begin
              heads_r <= quo_r;
              sect_r  <= 32'(sect_r * d_r);
            end
            default: begin
              sect_r <= quo_r;
              // the geometry product never grows, so this product fits 32 bits
              if (heads_r * d_r < HEAD_LIMIT) begin
                heads_r <= 32'(heads_r * d_r);
              end else begin
                cyl_r <= 32'(cyl_r * d_r);
              end
            end
          endcase
          state_r <= ST_DIV_GO;
        end
        ST_FIT_INIT: begin
          cap_r   <= 48'(cyl_r * heads_r);
          idx_r   <= '0;
          best_r  <= '0;
          space_r <= '0;
          n_r     <= (9'(types_r) > DEPTH9) ? DEPTH9 : 9'(types_r);
          state_r <= ST_FIT_RD;
        end
        ST_FIT_RD: begin
          if (idx_r == 9'd0) begin
            cap_r <= 48'(cap_r[31:0] * sect_r[7:0]);
          end
          if (idx_r >= n_r) begin
            state_r <= ST_FIT_DONE;
          end else begin
            state_r <= ST_FIT_MUL;
          end
        end
        ST_FIT_MUL: begin
          ch_r    <= 24'(rd_r[15:0] * rd_r[23:16]);
          state_r <= ST_FIT_CMP;
        end
        ST_FIT_CMP: begin
          if (48'(ch_r * rd_r[31:24]) <= cap_r &&
              (best_r == 7'd0 || cap_r - 48'(ch_r * rd_r[31:24]) < space_r)) begin
            space_r <= cap_r - 48'(ch_r * rd_r[31:24]);
            best_r  <= 7'(idx_r + 9'd1);
          end
          idx_r   <= idx_r + 9'd1;
          state_r <= ST_FIT_RD;
        end
        ST_FIT_DONE: begin
          if (best_r == 7'd0) begin
            space_r <= cap_r;
          end
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r          <= 1'b1;
            out_r.verdict        <= verdict_r;
            out_r.unused_kb      <= unused_r;
            out_r.many_cylinders <= many_r;
            out_r.suggest        <= sugg_r;
            out_r.new_cylinders  <= sugg_r ? cyl_r : '0;
            out_r.new_heads      <= sugg_r ? heads_r : '0;
            out_r.new_sectors    <= sugg_r ? sect_r : '0;
            out_r.best_type      <= sugg_r ? best_r : '0;
            out_r.leftover_kb    <= sugg_r ? 31'(space_r >> 1) : '0;
            out_r.stuck_on_prime <= sugg_r && stuck_r;
            state_r              <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `CHS_ASSERT_IMP(a_ready_idle, in_ch.ready, state_r == ST_IDLE)
  `CHS_ASSERT_NEXT(a_out_once, state_r == ST_OUT && (!out_valid_r || out_ch.ready), out_valid_r && state_r == ST_IDLE)
  `CHS_ASSERT_IMP(a_best_range, out_valid_r, {2'b0, out_r.best_type} <= DEPTH9)

endmodule

[tb/sv/chs_geometry_checker.sv]
// ----------------------------------------------------------------------------
// chs geometry translator checker
// watches the input, result and configuration channels of the translator,
// keeps its own drive-type table and search length, predicts every diagnose
// result and compares each result beat field by field with the oldest one
// ----------------------------------------------------------------------------
module chs_geometry_checker
  import chs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  chs_in_t    in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  chs_out_t   out_data,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [6:0] cfg_data,
  output int         fail_count,
  output int         pending
);

  localparam int DEPTH = 64;

  logic [31:0] drive_table [DEPTH];
  logic [6:0]  search_len;
  chs_out_t    verdicts_due [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    search_len = TYPES_RESET;
  end

  function automatic logic [31:0] first_factor(logic [31:0] v, logic [31:0] from);
    logic [31:0] d;
    d = from;
    while (d < v && (v % d) != 0) d++;
    return d;
  endfunction

  function automatic chs_out_t predict_geometry(chs_in_t it);
    longint unsigned phys, bios, cap, ec, space;
    logic [31:0] cyl, hd, sec, d, e;
    int unsigned best, n;
    chs_out_t r;
    r     = '0;
    space = 0;
    best  = 0;
    phys  = longint'(it.phys_cylinders) * it.phys_heads * it.phys_sectors;
    bios  = longint'(it.bios_cylinders) * it.bios_heads * it.bios_sectors;
    r.verdict = (bios < phys) ? VERDICT_SMALLER :
                (bios == phys) ? VERDICT_EQUAL : VERDICT_LARGER;
    r.unused_kb      = (bios < phys) ? 31'((phys - bios) >> 1) : 31'd0;
    r.many_cylinders = (32'(it.bios_cylinders) >= CYL_LIMIT);
    r.suggest        = (bios != phys) || r.many_cylinders;
    if (!r.suggest) return r;

    cyl = 32'(it.phys_cylinders);
    hd  = 32'(it.phys_heads);
    sec = 32'(it.phys_sectors);

    // divisor search resumes from the last factor found within each stage
    d = 2;
    while (cyl >= CYL_LIMIT) begin
      d = first_factor(cyl, d);
      if (d >= cyl) break;
      cyl = cyl / d;
      hd  = hd * d;
    end
    d = 2;
    while (hd >= HEAD_LIMIT) begin
      d = first_factor(hd, d);
      if (d >= hd) begin
        r.stuck_on_prime = 1'b1;
        break;
      end
      hd  = hd / d;
      sec = sec * d;
    end
    d = 2;
    while (sec >= SECT_LIMIT) begin
      d = first_factor(sec, d);
      if (d >= sec) begin
        r.stuck_on_prime = 1'b1;
        break;
      end
      sec = sec / d;
      if (longint'(hd) * d < HEAD_LIMIT) hd = hd * d;
      else cyl = cyl * d;
    end

    cap = longint'(cyl) * hd * sec;
    n   = (search_len > DEPTH) ? DEPTH : search_len;
    for (int unsigned i = 0; i < n; i++) begin
      e  = drive_table[i];
      ec = longint'(e[15:0]) * e[23:16] * e[31:24];
      if (ec <= cap && (best == 0 || cap - ec < space)) begin
        space = cap - ec;
        best  = i + 1;
      end
    end
    if (best == 0) space = cap;

    r.new_cylinders = cyl;
    r.new_heads     = hd;
    r.new_sectors   = sec;
    r.best_type     = 7'(best);
    r.leftover_kb   = 31'(space >> 1);
    return r;
  endfunction

  task automatic note_field(string field, longint unsigned want, longint unsigned got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    end
  endtask

  always @(posedge clk) begin
    chs_out_t want;
    if (!rst_n) begin
      verdicts_due.delete();
      search_len = TYPES_RESET;
    end else begin
      if (cfg_valid && cfg_ready) search_len = cfg_data;
      if (in_valid && in_ready) begin
        if (in_data.kind == KIND_LOAD)
          drive_table[in_data.entry_index] = {in_data.entry_sectors, in_data.entry_heads,
                                              in_data.entry_cylinders};
        else
          verdicts_due.push_back(predict_geometry(in_data));
      end
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("result beat with nothing outstanding: %p", out_data);
        end else begin
          want = verdicts_due.pop_front();
          note_field("verdict", want.verdict, out_data.verdict);
          note_field("unused_kb", want.unused_kb, out_data.unused_kb);
          note_field("many_cylinders", want.many_cylinders, out_data.many_cylinders);
          note_field("suggest", want.suggest, out_data.suggest);
          note_field("new_cylinders", want.new_cylinders, out_data.new_cylinders);
          note_field("new_heads", want.new_heads, out_data.new_heads);
          note_field("new_sectors", want.new_sectors, out_data.new_sectors);
          note_field("best_type", want.best_type, out_data.best_type);
          note_field("leftover_kb", want.leftover_kb, out_data.leftover_kb);
          note_field("stuck_on_prime", want.stuck_on_prime, out_data.stuck_on_prime);
        end
      end
    end
    pending = verdicts_due.size();
  end

endmodule

[tb/sv/tb_chs_geometry_translator_unit.sv]
// ----------------------------------------------------------------------------
// chs geometry translator testbench
// fills the drive-type table, runs directed diagnose beats over the corner
// geometries, then random loads and diagnoses under several search lengths,
// with random gaps and stalls on both channels; the checker does the comparing
// ----------------------------------------------------------------------------
module tb_chs_geometry_translator_unit;
  import chs_pkg::*;

  localparam int STALL_LIMIT = 200000;
  localparam int IN_W = $bits(chs_in_t);

  logic       clk;
  logic       rst_n;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [6:0] cfg_data;
  int         fail_count;
  int         pending;
  int         stall_cycles;
  bit         hold_armed;
  bit         hold_taken;

  chs_if #(.T(chs_in_t))  in_ch ();
  chs_if #(.T(chs_out_t)) out_ch ();

  chs_geometry_translator_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  chs_geometry_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (in_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // no beat on any channel for too long means the block has hung
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  // result side: bursts of ready with random holes, one long hold-off when armed
  initial begin
    int run_len, gap;
    out_ch.ready = 1'b0;
    hold_taken   = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_armed && !hold_taken) begin
        hold_taken = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (500) @(posedge clk);
      end else begin
        run_len = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 8);
        out_ch.ready <= 1'b1;
        repeat (run_len) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  function automatic chs_in_t drive_beat(int pc, int ph, int ps, int bc, int bh, int bs);
    chs_in_t it;
    it = chs_in_t'(IN_W'({$urandom, $urandom, $urandom, $urandom}));
    it.kind           = KIND_DIAGNOSE;
    it.phys_cylinders = 16'(pc);
    it.phys_heads     = 8'(ph);
    it.phys_sectors   = 8'(ps);
    it.bios_cylinders = 16'(bc);
    it.bios_heads     = 8'(bh);
    it.bios_sectors   = 8'(bs);
    return it;
  endfunction

  function automatic chs_in_t load_beat(int idx, int c, int h, int s);
    chs_in_t it;
    it = chs_in_t'(IN_W'({$urandom, $urandom, $urandom, $urandom}));
    it.kind            = KIND_LOAD;
    it.entry_index     = 6'(idx);
    it.entry_cylinders = 16'(c);
    it.entry_heads     = 8'(h);
    it.entry_sectors   = 8'(s);
    return it;
  endfunction

  // cylinder counts keep an odd part under 1024 so trial division stays short
  function automatic chs_in_t random_drive();
    int pc, ph, ps;
    case ($urandom_range(0, 3))
      0:       pc = $urandom_range(0, 1023);
      1, 2:    pc = $urandom_range(1, 1023) << $urandom_range(1, 6);
      default: pc = $urandom_range(1, 255) << 8;
    endcase
    ph = $urandom_range(0, 255);
    ps = $urandom_range(0, 255);
    case ($urandom_range(0, 3))
      0:       return drive_beat(pc, ph, ps, pc, ph, ps);
      1:       return drive_beat(pc, ph, ps, pc, ps, ph);
      2:       return drive_beat(pc, ph, ps, $urandom_range(0, 65535), $urandom_range(0, 255),
                                 $urandom_range(0, 255));
      default: return drive_beat(pc, ph, ps, $urandom_range(1024, 65535), ph, ps);
    endcase
  endfunction

  function automatic chs_in_t random_entry(int idx);
    if ($urandom_range(0, 2) == 0)
      return load_beat(idx, $urandom_range(1, 1023), $urandom_range(1, 16),
                       $urandom_range(17, 63));
    return load_beat(idx, $urandom_range(0, 65535), $urandom_range(0, 255),
                     $urandom_range(0, 255));
  endfunction

  // called at a rising edge; valid stays up across back-to-back beats
  task automatic send_beat(chs_in_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    // a load beat may still be in flight after the last result
    repeat (10) @(posedge clk);
  endtask

  task automatic write_search_len(logic [6:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [6:0] span_list [6];
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    hold_armed  = 1'b0;
    rst_n       = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // whole table written before any search can touch it
    for (int i = 0; i < 61; i++) send_beat(random_entry(i));
    send_beat(load_beat(61, 100, 16, 63));
    send_beat(load_beat(62, 100, 16, 63));
    send_beat(load_beat(63, 0, 255, 255));

    send_beat(drive_beat(100, 16, 63, 100, 16, 63));
    send_beat(drive_beat(0, 0, 0, 0, 0, 0));
    send_beat(drive_beat(65535, 255, 255, 65535, 255, 255));
    send_beat(drive_beat(500, 16, 63, 1000, 16, 63));
    send_beat(drive_beat(4000, 16, 63, 1000, 16, 63));
    send_beat(drive_beat(1023, 16, 63, 1023, 16, 63));
    send_beat(drive_beat(1024, 16, 63, 1024, 16, 63));
    send_beat(drive_beat(1031, 16, 63, 1000, 16, 63));   // prime cylinders
    send_beat(drive_beat(100, 4, 67, 0, 0, 0));          // prime sectors
    send_beat(drive_beat(100, 200, 128, 100, 16, 63));   // sectors spill into cylinders
    send_beat(drive_beat(1, 1, 1, 0, 0, 0));             // capacity of a single sector
    send_beat(drive_beat(4096, 255, 255, 0, 0, 0));
    send_beat(drive_beat(0, 0, 0, 65535, 255, 255));
    send_beat(drive_beat(10, 250, 251, 20, 250, 251));

    span_list = '{7'd64, 7'd1, 7'd127, 7'd0, 7'($urandom_range(1, 64)), 7'd64};
    foreach (span_list[p]) begin
      write_search_len(span_list[p]);
      if (p == 1) hold_armed = 1'b1;
      for (int k = 0; k < 10; k++) begin
        if ($urandom_range(0, 5) == 0) send_beat(random_entry($urandom_range(0, 63)));
        else send_beat(random_drive());
      end
    end

    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
